### hdl/cfp_pkg.sv
// cfp_pkg: types and constants shared by the command frame parser
// front end, transaction queue and result back end; no dependencies
`default_nettype none

package cfp_pkg;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_OP     = 3'd1,
    PH_TARGET = 3'd2,
    PH_LEN    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    RES_CMD      = 2'd0,
    RES_DATA     = 2'd1,
    RES_BADCHECK = 2'd2,
    RES_OVERFLOW = 2'd3
  } res_type_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_HEAD  = 2'd1,
    BK_FETCH = 2'd2,
    BK_DATA  = 2'd3
  } back_state_e;

  localparam logic [7:0] CFG_START       = 8'd0;
  localparam logic [7:0] CFG_OP_REQ_ALL  = 8'd1;
  localparam logic [7:0] CFG_OP_WRITE    = 8'd2;
  localparam logic [7:0] CFG_OP_READ     = 8'd3;

  localparam logic [7:0] START_RESET     = 8'd60;
  localparam logic [7:0] OP_REQ_ALL_RST  = 8'd0;
  localparam logic [7:0] OP_WRITE_RST    = 8'd1;
  localparam logic [7:0] OP_READ_RST     = 8'd2;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] op_req_all;
    logic [7:0] op_write;
    logic [7:0] op_read;
  } cfg_t;

  // one frame outcome handed from front end to back end
  typedef struct packed {
    res_type_e  rtype;
    logic [7:0] operation;
    logic [7:0] target;
    logic [7:0] length;
    logic       is_write;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/cfp_front.sv
// cfp_front: frame hunt and parse of received bytes, payload capture and
// checksum; pushes frame outcomes into the queue; uses cfp_pkg
`default_nettype none

module cfp_front #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW = 5
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  cfp_pkg::cfg_t   cfg_i,
  input  wire             rx_valid_i,
  output logic            rx_ready_o,
  input  wire  [7:0]      rx_byte_i,
  input  wire             back_busy_i,
  input  wire             q_full_i,
  output logic            push_o,
  output cfp_pkg::cmd_t   push_cmd_o,
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output logic [7:0]      mem_wdata_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  cfp_pkg::phase_e phase_q, phase_d;
  logic [7:0] op_q, op_d;
  logic [7:0] tgt_q, tgt_d;
  logic [7:0] len_q, len_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] chk_q, chk_d;
  logic       acc;
  logic       op_ok;
  logic [7:0] idx;

  assign acc   = rx_valid_i && rx_ready_o;
  assign op_ok = (rx_byte_i == cfg_i.op_req_all) || (rx_byte_i == cfg_i.op_write) ||
                 (rx_byte_i == cfg_i.op_read);
  assign idx   = len_q - rem_q;

  always_comb begin
    case (phase_q)
      cfp_pkg::PH_LEN,
      cfp_pkg::PH_CHECK: rx_ready_o = !q_full_i;
      cfp_pkg::PH_DATA:  rx_ready_o = !back_busy_i;
      default:           rx_ready_o = 1'b1;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    tgt_d   = tgt_q;
    len_d   = len_q;
    rem_d   = rem_q;
    chk_d   = chk_q;
    if (acc) begin
      case (phase_q)
        cfp_pkg::PH_OP: begin
          if (op_ok) begin
            op_d    = rx_byte_i;
            chk_d   = chk_q ^ rx_byte_i;
            phase_d = cfp_pkg::PH_TARGET;
          end else begin
            op_d    = 8'd0;
            phase_d = cfp_pkg::PH_HUNT;
          end
        end
        cfp_pkg::PH_TARGET: begin
          tgt_d   = rx_byte_i;
          chk_d   = chk_q ^ rx_byte_i;
          phase_d = cfp_pkg::PH_LEN;
        end
        cfp_pkg::PH_LEN: begin
          len_d = rx_byte_i;
          rem_d = rx_byte_i;
          chk_d = chk_q ^ rx_byte_i;
          if (rx_byte_i > MaxLen) begin
            phase_d = cfp_pkg::PH_HUNT;
          end else if (rx_byte_i != 8'd0) begin
            phase_d = cfp_pkg::PH_DATA;
          end else begin
            phase_d = cfp_pkg::PH_CHECK;
          end
        end
        cfp_pkg::PH_DATA: begin
          chk_d = chk_q ^ rx_byte_i;
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            phase_d = cfp_pkg::PH_CHECK;
          end
        end
        cfp_pkg::PH_CHECK: begin
          phase_d = cfp_pkg::PH_HUNT;
        end
        default: begin
          phase_d = cfp_pkg::PH_HUNT;
          if (rx_byte_i == cfg_i.start_byte) begin
            chk_d   = rx_byte_i;
            phase_d = cfp_pkg::PH_OP;
          end
        end
      endcase
    end
  end

  always_comb begin
    push_o     = 1'b0;
    push_cmd_o = '{rtype: cfp_pkg::RES_CMD, operation: op_q, target: tgt_q,
                   length: len_q, is_write: 1'b0};
    mem_we_o   = 1'b0;
    if (acc) begin
      case (phase_q)
        cfp_pkg::PH_LEN: begin
          if (rx_byte_i > MaxLen) begin
            push_o            = 1'b1;
            push_cmd_o.rtype  = cfp_pkg::RES_OVERFLOW;
            push_cmd_o.length = rx_byte_i;
          end
        end
        cfp_pkg::PH_DATA: begin
          mem_we_o = 1'b1;
        end
        cfp_pkg::PH_CHECK: begin
          push_o = 1'b1;
          if (rx_byte_i == chk_q) begin
            push_cmd_o.rtype    = cfp_pkg::RES_CMD;
            push_cmd_o.is_write = (op_q == cfg_i.op_write) && (len_q != 8'd0);
          end else begin
            push_cmd_o.rtype = cfp_pkg::RES_BADCHECK;
          end
        end
        default: ;
      endcase
    end
  end

  assign mem_waddr_o = idx[AW-1:0];
  assign mem_wdata_o = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfp_pkg::PH_HUNT;
      op_q    <= 8'd0;
      tgt_q   <= 8'd0;
      len_q   <= 8'd0;
      rem_q   <= 8'd0;
      chk_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      tgt_q   <= tgt_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      chk_q   <= chk_d;
    end
  end

endmodule

`default_nettype wire

### hdl/cfp_fifo.sv
// cfp_fifo: two-entry queue of frame outcomes between front end and
// back end; uses cfp_pkg
`default_nettype none

module cfp_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  cfp_pkg::cmd_t  push_cmd_i,
  input  wire            pop_i,
  output cfp_pkg::cmd_t  head_o,
  output logic           full_o,
  output logic           empty_o
);

  cfp_pkg::cmd_t mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hdl/cfp_back.sv
// cfp_back: payload memory and result sequencer; pops frame outcomes and
// emits the command, error and payload results; uses cfp_pkg
`default_nettype none

module cfp_back #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW = 5
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             mem_we_i,
  input  wire  [AW-1:0]   mem_waddr_i,
  input  wire  [7:0]      mem_wdata_i,
  input  cfp_pkg::cmd_t   head_i,
  input  wire             q_empty_i,
  output logic            pop_o,
  output logic            busy_o,
  output logic            res_valid_o,
  input  wire             res_ready_i,
  output logic [1:0]      result_type_o,
  output logic [7:0]      operation_o,
  output logic [7:0]      target_o,
  output logic [7:0]      payload_length_o,
  output logic [7:0]      data_byte_o,
  output logic            last_o
);

  logic [7:0] mem_q [MAX_PAYLOAD];
  logic [7:0] rd_q;

  cfp_pkg::back_state_e state_q, state_d;
  cfp_pkg::cmd_t cur_q, cur_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          acc;
  logic          at_end;

  assign acc    = res_valid_o && res_ready_i;
  assign at_end = ((8'(idx_q) + 8'd1) == cur_q.length);

  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_q[mem_waddr_i] <= mem_wdata_i;
    end
    rd_q <= mem_q[idx_q];
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    case (state_q)
      cfp_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          cur_d   = head_i;
          idx_d   = '0;
          state_d = cfp_pkg::BK_HEAD;
        end
      end
      cfp_pkg::BK_HEAD: begin
        if (acc) begin
          state_d = cur_q.is_write ? cfp_pkg::BK_FETCH : cfp_pkg::BK_IDLE;
        end
      end
      cfp_pkg::BK_FETCH: begin
        state_d = cfp_pkg::BK_DATA;
      end
      cfp_pkg::BK_DATA: begin
        if (acc) begin
          if (at_end) begin
            state_d = cfp_pkg::BK_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = cfp_pkg::BK_FETCH;
          end
        end
      end
      default: begin
        state_d = cfp_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_o      = 1'b0;
    result_type_o    = cur_q.rtype;
    data_byte_o      = 8'd0;
    last_o           = 1'b1;
    busy_o           = 1'b1;
    operation_o      = cur_q.operation;
    target_o         = cur_q.target;
    payload_length_o = cur_q.length;
    case (state_q)
      cfp_pkg::BK_IDLE: begin
        busy_o = 1'b0;
      end
      cfp_pkg::BK_HEAD: begin
        res_valid_o = 1'b1;
        last_o      = !cur_q.is_write;
      end
      cfp_pkg::BK_DATA: begin
        res_valid_o   = 1'b1;
        result_type_o = cfp_pkg::RES_DATA;
        data_byte_o   = rd_q;
        last_o        = at_end;
      end
      default: begin
        last_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfp_pkg::BK_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

`default_nettype wire

### hdl/command_frame_parser_xor_check.sv
// Command frame parser with XOR checksum. Received bytes are taken one per
// cycle by the front end when it does not stall (start byte hunt, opcode
// match, target, length, payload, checksum); payload bytes are written to a
// MAX_PAYLOAD-entry memory. Each finished frame leaves one outcome in a
// two-entry queue, and the back end turns it into results: it pops the
// queue, presents the command or error result, then for each payload byte of
// a write reads the memory and then presents the byte.
// Payload bytes of a new frame stall while the queue or the back end still
// hold work, since front and back end share the payload memory. The register
// port is always ready; writes beyond the four registers are ignored.
// Depends on cfp_pkg, cfp_front, cfp_fifo and cfp_back.
`default_nettype none

module command_frame_parser_xor_check #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire  [7:0] cfg_index_i,
  input  wire  [7:0] cfg_data_i,
  input  wire        rx_valid_i,
  output logic       rx_ready_o,
  input  wire  [7:0] rx_byte_i,
  output logic       res_valid_o,
  input  wire        res_ready_i,
  output logic [1:0] result_type_o,
  output logic [7:0] operation_o,
  output logic [7:0] target_o,
  output logic [7:0] payload_length_o,
  output logic [7:0] data_byte_o,
  output logic       last_o
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  cfp_pkg::cfg_t cfg_q, cfg_d;
  cfp_pkg::cmd_t push_cmd, head;
  logic          push, pop, q_full, q_empty, back_busy;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        cfp_pkg::CFG_START:      cfg_d.start_byte = cfg_data_i;
        cfp_pkg::CFG_OP_REQ_ALL: cfg_d.op_req_all = cfg_data_i;
        cfp_pkg::CFG_OP_WRITE:   cfg_d.op_write   = cfg_data_i;
        cfp_pkg::CFG_OP_READ:    cfg_d.op_read    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{start_byte: cfp_pkg::START_RESET, op_req_all: cfp_pkg::OP_REQ_ALL_RST,
                 op_write: cfp_pkg::OP_WRITE_RST, op_read: cfp_pkg::OP_READ_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cfp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW(AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .back_busy_i (back_busy),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  cfp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  logic bk_busy;

  assign back_busy = bk_busy || !q_empty;

  cfp_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW(AW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mem_we_i         (mem_we),
    .mem_waddr_i      (mem_waddr),
    .mem_wdata_i      (mem_wdata),
    .head_i           (head),
    .q_empty_i        (q_empty),
    .pop_o            (pop),
    .busy_o           (bk_busy),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .result_type_o    (result_type_o),
    .operation_o      (operation_o),
    .target_o         (target_o),
    .payload_length_o (payload_length_o),
    .data_byte_o      (data_byte_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

### tb/sv/command_frame_parser_xor_check_test.sv
// command_frame_parser_xor_check_test: self-checking testbench for the command frame parser;
// a local frame predictor checks every result transaction, with random idling on both sides
// depends on cfp_pkg and command_frame_parser_xor_check
module command_frame_parser_xor_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD = 32;
  localparam int HOLD_CYCLES = 40;
  localparam int CYCLE_LIMIT = 800000;
  localparam logic [7:0] CFG_UNUSED = 8'hff;

  typedef struct {
    cfp_pkg::res_type_e rtype;
    logic [7:0]         operation;
    logic [7:0]         target;
    logic [7:0]         length;
    logic [7:0]         data;
    logic               last;
  } frame_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_index_i = 8'h00;
  logic [7:0] cfg_data_i = 8'h00;
  logic       rx_valid_i = 1'b0;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       res_valid_o;
  logic       res_ready_i = 1'b0;
  logic [1:0] result_type_o;
  logic [7:0] operation_o;
  logic [7:0] target_o;
  logic [7:0] payload_length_o;
  logic [7:0] data_byte_o;
  logic       last_o;

  // predictor state
  cfp_pkg::cfg_t   parser_regs = '{cfp_pkg::START_RESET, cfp_pkg::OP_REQ_ALL_RST,
                                   cfp_pkg::OP_WRITE_RST, cfp_pkg::OP_READ_RST};
  cfp_pkg::phase_e parse_phase = cfp_pkg::PH_HUNT;
  logic [7:0] frame_op = 8'h00;
  logic [7:0] frame_tgt = 8'h00;
  logic [7:0] frame_len = 8'h00;
  logic [7:0] bytes_left = 8'h00;
  logic [7:0] xor_sum = 8'h00;
  logic [7:0] stored_payload [MAX_PAYLOAD];

  frame_result_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int feed_idle_pct = 0;
  int sink_stall_pct = 0;

  command_frame_parser_xor_check #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_o      (rx_ready_o),
    .rx_byte_i       (rx_byte_i),
    .res_valid_o     (res_valid_o),
    .res_ready_i     (res_ready_i),
    .result_type_o   (result_type_o),
    .operation_o     (operation_o),
    .target_o        (target_o),
    .payload_length_o(payload_length_o),
    .data_byte_o     (data_byte_o),
    .last_o          (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("command_frame_parser_xor_check_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    res_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic void queue_result(cfp_pkg::res_type_e rtype, logic [7:0] data,
                                       logic last);
    frame_result_t r;
    r.rtype = rtype;
    r.operation = frame_op;
    r.target = frame_tgt;
    r.length = frame_len;
    r.data = data;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void parse_rx_byte(logic [7:0] b);
    int  idx;
    bit  is_write;
    case (parse_phase)
      cfp_pkg::PH_OP: begin
        if (b == parser_regs.op_req_all || b == parser_regs.op_write ||
            b == parser_regs.op_read) begin
          frame_op = b;
          xor_sum ^= b;
          parse_phase = cfp_pkg::PH_TARGET;
        end else begin
          frame_op = 8'h00;
          parse_phase = cfp_pkg::PH_HUNT;
        end
      end
      cfp_pkg::PH_TARGET: begin
        frame_tgt = b;
        xor_sum ^= b;
        parse_phase = cfp_pkg::PH_LEN;
      end
      cfp_pkg::PH_LEN: begin
        frame_len = b;
        bytes_left = b;
        xor_sum ^= b;
        if (b > MAX_PAYLOAD) begin
          queue_result(cfp_pkg::RES_OVERFLOW, 8'h00, 1'b1);
          parse_phase = cfp_pkg::PH_HUNT;
        end else if (b != 8'h00) begin
          parse_phase = cfp_pkg::PH_DATA;
        end else begin
          parse_phase = cfp_pkg::PH_CHECK;
        end
      end
      cfp_pkg::PH_DATA: begin
        idx = int'(frame_len) - int'(bytes_left);
        if (idx < MAX_PAYLOAD) stored_payload[idx] = b;
        xor_sum ^= b;
        if (bytes_left != 8'h00) bytes_left -= 8'h01;
        if (bytes_left == 8'h00) parse_phase = cfp_pkg::PH_CHECK;
      end
      cfp_pkg::PH_CHECK: begin
        if (b == xor_sum) begin
          is_write = (frame_op == parser_regs.op_write) && (frame_len != 8'h00);
          queue_result(cfp_pkg::RES_CMD, 8'h00, !is_write);
          if (is_write) begin
            for (int i = 0; i < int'(frame_len); i++) begin
              queue_result(cfp_pkg::RES_DATA, stored_payload[i],
                           (i + 1 == int'(frame_len)));
            end
          end
        end else begin
          queue_result(cfp_pkg::RES_BADCHECK, 8'h00, 1'b1);
        end
        parse_phase = cfp_pkg::PH_HUNT;
      end
      default: begin
        parse_phase = cfp_pkg::PH_HUNT;
        if (b == parser_regs.start_byte) begin
          xor_sum = b;
          parse_phase = cfp_pkg::PH_OP;
        end
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result_type: expected none, got %0h", result_type_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_type", {6'b0, want.rtype}, {6'b0, result_type_o});
        check_field("operation", want.operation, operation_o);
        check_field("target", want.target, target_o);
        check_field("payload_length", want.length, payload_length_o);
        check_field("data_byte", want.data, data_byte_o);
        check_field("last", {7'b0, want.last}, {7'b0, last_o});
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < feed_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    parse_rx_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] op, input logic [7:0] tgt,
                            input logic [7:0] data[$], input bit corrupt);
    logic [7:0] sum;
    sum = parser_regs.start_byte ^ op ^ tgt ^ 8'(data.size());
    send_byte(parser_regs.start_byte);
    send_byte(op);
    send_byte(tgt);
    send_byte(8'(data.size()));
    foreach (data[i]) begin
      sum ^= data[i];
      send_byte(data[i]);
    end
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      cfp_pkg::CFG_START:      parser_regs.start_byte = value;
      cfp_pkg::CFG_OP_REQ_ALL: parser_regs.op_req_all = value;
      cfp_pkg::CFG_OP_WRITE:   parser_regs.op_write = value;
      cfp_pkg::CFG_OP_READ:    parser_regs.op_read = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_for_idle();
    rx_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (HOLD_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_frame(output int nbytes);
    int         kind;
    int         len;
    int         cut;
    logic [7:0] op;
    logic [7:0] bad_op;
    logic [7:0] data[$];
    kind = $urandom_range(99);
    nbytes = 0;
    case ($urandom_range(3))
      0:       op = parser_regs.op_req_all;
      1:       op = parser_regs.op_read;
      default: op = parser_regs.op_write;
    endcase
    if (kind < 6) begin
      // line noise
      send_byte(8'($urandom_range(255)));
      nbytes = 1;
    end else if (kind < 12) begin
      do bad_op = 8'($urandom_range(255));
      while (bad_op == parser_regs.op_req_all || bad_op == parser_regs.op_write ||
             bad_op == parser_regs.op_read);
      send_byte(parser_regs.start_byte);
      send_byte(bad_op);
      nbytes = 2;
    end else if (kind < 18) begin
      send_byte(parser_regs.start_byte);
      send_byte(op);
      send_byte(8'($urandom_range(255)));
      send_byte(($urandom_range(3) == 0) ? 8'hff : 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      nbytes = 4;
    end else begin
      case ($urandom_range(99)) inside
        [0:79]:  len = $urandom_range(6);
        [80:94]: len = $urandom_range(7, MAX_PAYLOAD - 1);
        default: len = MAX_PAYLOAD;
      endcase
      repeat (len) data.push_back(8'($urandom_range(255)));
      if (kind < 22) begin
        // frame cut short, the next bytes land inside it
        cut = $urandom_range(3 + len);
        send_byte(parser_regs.start_byte);
        if (cut > 0) send_byte(op);
        if (cut > 1) send_byte(8'($urandom_range(255)));
        if (cut > 2) send_byte(8'(len));
        for (int i = 3; i < cut; i++) send_byte(data[i - 3]);
        nbytes = cut + 1;
      end else begin
        send_frame(op, 8'($urandom_range(255)), data, kind < 32);
        nbytes = len + 5;
      end
    end
  endtask

  task automatic run_random_frames(input int idle_pct, input int stall_pct, input int budget);
    int sent;
    int n;
    feed_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      send_random_frame(n);
      sent += n;
    end
    wait_for_idle();
  endtask

  task automatic test_directed_frames();
    logic [7:0] edge_bytes[$];
    logic [7:0] no_bytes[$];
    edge_bytes = {8'h00, 8'hff};
    send_frame(parser_regs.op_write, 8'hff, edge_bytes, 1'b0);
    send_frame(parser_regs.op_write, 8'h00, no_bytes, 1'b0);
    send_frame(parser_regs.op_read, 8'h5a, no_bytes, 1'b1);
    // rejected operation equal to the start byte must not open a frame
    send_byte(parser_regs.start_byte);
    send_byte(parser_regs.start_byte);
    send_byte(parser_regs.start_byte);
    send_byte(parser_regs.op_req_all);
    send_byte(8'h81);
    send_byte(8'(MAX_PAYLOAD + 1));
    wait_for_idle();
  endtask

  task automatic test_reset_registers();
    run_random_frames(0, 0, 65);
  endtask

  task automatic test_extreme_registers();
    write_reg(cfp_pkg::CFG_START, 8'hff);
    write_reg(cfp_pkg::CFG_OP_REQ_ALL, 8'h00);
    write_reg(cfp_pkg::CFG_OP_WRITE, 8'hff);
    write_reg(cfp_pkg::CFG_OP_READ, 8'h7f);
    run_random_frames(76, 0, 65);
  endtask

  task automatic test_overlapping_opcodes();
    write_reg(cfp_pkg::CFG_START, 8'h00);
    write_reg(cfp_pkg::CFG_OP_REQ_ALL, 8'ha5);
    write_reg(cfp_pkg::CFG_OP_WRITE, 8'ha5);
    write_reg(cfp_pkg::CFG_OP_READ, 8'ha5);
    run_random_frames(0, 76, 65);
  endtask

  task automatic test_random_registers();
    write_reg(cfp_pkg::CFG_START, 8'($urandom_range(255)));
    write_reg(cfp_pkg::CFG_OP_REQ_ALL, 8'($urandom_range(255)));
    write_reg(cfp_pkg::CFG_OP_WRITE, 8'($urandom_range(255)));
    write_reg(cfp_pkg::CFG_OP_READ, 8'($urandom_range(255)));
    write_reg(CFG_UNUSED, 8'($urandom_range(255)));
    run_random_frames(13, 13, 65);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_reset_registers();
    test_extreme_registers();
    test_overlapping_opcodes();
    test_random_registers();
    if (error_count == 0) begin
      $display("command_frame_parser_xor_check_test: done, clean");
    end else begin
      $display("command_frame_parser_xor_check_test: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/cfp_pkg.sv
hdl/cfp_front.sv
hdl/cfp_fifo.sv
hdl/cfp_back.sv
hdl/command_frame_parser_xor_check.sv
tb/sv/command_frame_parser_xor_check_test.sv
